// ===== hw/rtl/mrsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running-status parser package
// Byte codes and decoded message kinds shared by the parser RTL.
// ----------------------------------------------------------------------------
package mrsp_pkg;

   localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
   localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
   localparam logic [7:0] BYTE_COMMON_MIN   = 8'hF1;
   localparam logic [7:0] NO_STATUS         = 8'h00;

   localparam logic [3:0] TYPE_NOTE_OFF      = 4'h8;
   localparam logic [3:0] TYPE_NOTE_ON       = 4'h9;
   localparam logic [3:0] TYPE_POLY_PRESSURE = 4'hA;
   localparam logic [3:0] TYPE_CTRL          = 4'hB;
   localparam logic [3:0] TYPE_PROGRAM       = 4'hC;
   localparam logic [3:0] TYPE_PRESSURE      = 4'hD;
   localparam logic [3:0] TYPE_BEND          = 4'hE;
   localparam logic [3:0] TYPE_SYSTEM        = 4'hF;

   localparam logic [13:0] BEND_OFFSET = 14'h2000;

   typedef enum logic [2:0] {
      KIND_NOTE_OFF   = 3'd0,
      KIND_NOTE_ON    = 3'd1,
      KIND_CTRL       = 3'd2,
      KIND_PROGRAM    = 3'd3,
      KIND_BEND       = 3'd4,
      KIND_AFTERTOUCH = 3'd5
   } kind_type;

endpackage

// ===== hw/rtl/midi_running_status_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running-status parser
// Assembles channel-voice messages from a raw MIDI byte stream.
// ----------------------------------------------------------------------------
// One MIDI byte is taken per transfer, one per cycle while results drain: each
// byte is decoded combinationally against the small parser state (running
// status, held first data byte, sysex flag) and a completed message is loaded
// into the result register. The input is ready whenever that register is
// empty or is being drained in the same cycle, so a result appears the cycle
// after the byte that completes it. Realtime bytes are dropped, sysex content
// is skipped, and note-on with velocity zero is reported as note-off.
// ----------------------------------------------------------------------------
module midi_running_status_parser_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_midi_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_status_byte,
   output logic [3:0]         rsp_channel,
   output logic [2:0]         rsp_event_kind,
   output logic [6:0]         rsp_data_first,
   output logic [6:0]         rsp_data_second,
   output logic signed [13:0] rsp_bend_value
);

   logic [7:0]  running_status_ff, running_status_in;
   logic [6:0]  held_first_ff, held_first_in;
   logic        two_needed_ff, two_needed_in;
   logic        have_first_ff, have_first_in;
   logic        in_sysex_ff, in_sysex_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  status_ff, status_in;
   logic [2:0]  kind_ff, kind_in;
   logic [6:0]  first_ff, first_in;
   logic [6:0]  second_ff, second_in;
   logic [13:0] bend_ff, bend_in;

   logic        accept;
   logic        emit;
   logic        handle;
   logic [3:0]  msg_type;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      running_status_in = running_status_ff;
      held_first_in     = held_first_ff;
      two_needed_in     = two_needed_ff;
      have_first_in     = have_first_ff;
      in_sysex_in       = in_sysex_ff;
      emit              = 1'b0;
      handle            = 1'b1;
      first_in          = held_first_ff;
      second_in         = 7'd0;
      if (accept && (req_midi_byte < mrsp_pkg::BYTE_REALTIME_MIN)) begin
         if (in_sysex_ff) begin
            if (req_midi_byte == mrsp_pkg::BYTE_SYSEX_END) begin
               in_sysex_in = 1'b0;
               handle      = 1'b0;
            end else if (!req_midi_byte[7]) begin
               handle = 1'b0;
            end else begin
               in_sysex_in = 1'b0;
            end
         end
         if (handle) begin
            if (req_midi_byte[7]) begin
               have_first_in = 1'b0;
               if (req_midi_byte == mrsp_pkg::BYTE_SYSEX_START) begin
                  in_sysex_in       = 1'b1;
                  running_status_in = mrsp_pkg::NO_STATUS;
               end else if (req_midi_byte >= mrsp_pkg::BYTE_COMMON_MIN) begin
                  running_status_in = mrsp_pkg::NO_STATUS;
               end else begin
                  running_status_in = req_midi_byte;
                  two_needed_in = !((req_midi_byte[7:4] == mrsp_pkg::TYPE_PROGRAM) ||
                                    (req_midi_byte[7:4] == mrsp_pkg::TYPE_PRESSURE));
               end
            end else if (running_status_ff != mrsp_pkg::NO_STATUS) begin
               if (!have_first_ff) begin
                  held_first_in = req_midi_byte[6:0];
                  if (!two_needed_ff) begin
                     emit     = 1'b1;
                     first_in = req_midi_byte[6:0];
                  end else begin
                     have_first_in = 1'b1;
                  end
               end else begin
                  emit          = 1'b1;
                  second_in     = req_midi_byte[6:0];
                  have_first_in = 1'b0;
               end
            end
         end
      end
   end

   assign status_in = running_status_ff;
   assign msg_type  = running_status_ff[7:4];

   always_comb begin
      bend_in = 14'd0;
      case (msg_type)
         mrsp_pkg::TYPE_NOTE_OFF: kind_in = mrsp_pkg::KIND_NOTE_OFF;
         mrsp_pkg::TYPE_NOTE_ON: begin
            kind_in = (second_in == 7'd0) ? mrsp_pkg::KIND_NOTE_OFF : mrsp_pkg::KIND_NOTE_ON;
         end
         mrsp_pkg::TYPE_CTRL:    kind_in = mrsp_pkg::KIND_CTRL;
         mrsp_pkg::TYPE_PROGRAM: kind_in = mrsp_pkg::KIND_PROGRAM;
         mrsp_pkg::TYPE_BEND: begin
            kind_in = mrsp_pkg::KIND_BEND;
            bend_in = {second_in, first_in} + mrsp_pkg::BEND_OFFSET;
         end
         default:                kind_in = mrsp_pkg::KIND_AFTERTOUCH;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= mrsp_pkg::NO_STATUS;
         held_first_ff     <= 7'd0;
         two_needed_ff     <= 1'b0;
         have_first_ff     <= 1'b0;
         in_sysex_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         running_status_ff <= running_status_in;
         held_first_ff     <= held_first_in;
         two_needed_ff     <= two_needed_in;
         have_first_ff     <= have_first_in;
         in_sysex_ff       <= in_sysex_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         bend_ff   <= bend_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_byte = status_ff;
   assign rsp_channel     = status_ff[3:0];
   assign rsp_event_kind  = kind_ff;
   assign rsp_data_first  = first_ff;
   assign rsp_data_second = second_ff;
   assign rsp_bend_value  = $signed(bend_ff);

   // sysex always leaves running status cleared
   a_sysex_no_status: assert property (@(posedge clock) disable iff (reset)
      in_sysex_ff |-> (running_status_ff == mrsp_pkg::NO_STATUS))
      else $error("running status set inside sysex");

   a_held_first_ok: assert property (@(posedge clock) disable iff (reset)
      have_first_ff |-> (two_needed_ff && (running_status_ff != mrsp_pkg::NO_STATUS)))
      else $error("first data held without a two-byte status");

   a_result_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (status_ff[7] && (status_ff[7:4] != mrsp_pkg::TYPE_SYSTEM)))
      else $error("result carries a non channel-voice status");

   a_bend_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff != mrsp_pkg::KIND_BEND)) |-> (bend_ff == 14'd0))
      else $error("bend value on a non-bend result");

   a_realtime_inert: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_midi_byte >= mrsp_pkg::BYTE_REALTIME_MIN)) |=>
         (!rsp_valid_ff && $stable(running_status_ff) && $stable(have_first_ff) &&
          $stable(in_sysex_ff)))
      else $error("realtime byte disturbed parser state");

endmodule

// ===== bench/midi_message_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message checker
// Watches the byte and message channels of the running-status parser. It
// keeps its own copy of the parser state, queues the message that an
// accepted byte completes and compares every message transfer with the oldest
// entry. It reports mismatches and hands their count to the testbench top.
// ----------------------------------------------------------------------------
module midi_message_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_midi_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_status_byte,
   input  logic [3:0]         rsp_channel,
   input  logic [2:0]         rsp_event_kind,
   input  logic [6:0]         rsp_data_first,
   input  logic [6:0]         rsp_data_second,
   input  logic signed [13:0] rsp_bend_value,
   output int                 mismatch_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [7:0]         status_byte;
      logic [3:0]         channel;
      logic [2:0]         kind;
      logic [6:0]         data_first;
      logic [6:0]         data_second;
      logic signed [13:0] bend;
   } midi_msg_type;

   logic [7:0] cur_status = mrsp_pkg::NO_STATUS;
   logic [6:0] held_data = '0;
   logic       need_two = 1'b0;
   logic       have_first = 1'b0;
   logic       in_sysex = 1'b0;

   midi_msg_type expected_msgs[$];

   function automatic midi_msg_type decode_message(input logic [7:0] st,
                                                   input logic [6:0] d1,
                                                   input logic [6:0] d2);
      midi_msg_type m;
      m.status_byte = st;
      m.channel = st[3:0];
      m.data_first = d1;
      m.data_second = d2;
      m.bend = '0;
      case (st[7:4])
         mrsp_pkg::TYPE_NOTE_OFF: m.kind = mrsp_pkg::KIND_NOTE_OFF;
         mrsp_pkg::TYPE_NOTE_ON: begin
            if (d2 == 7'd0) m.kind = mrsp_pkg::KIND_NOTE_OFF;
            else m.kind = mrsp_pkg::KIND_NOTE_ON;
         end
         mrsp_pkg::TYPE_CTRL: m.kind = mrsp_pkg::KIND_CTRL;
         mrsp_pkg::TYPE_PROGRAM: m.kind = mrsp_pkg::KIND_PROGRAM;
         mrsp_pkg::TYPE_BEND: begin
            m.kind = mrsp_pkg::KIND_BEND;
            m.bend = {d2, d1} - mrsp_pkg::BEND_OFFSET;
         end
         default: m.kind = mrsp_pkg::KIND_AFTERTOUCH;
      endcase
      return m;
   endfunction

   // advances the parser copy by one byte; returns 1 when a message completes
   function automatic bit parse_byte(input logic [7:0] b, output midi_msg_type m);
      m = '0;
      if (b >= mrsp_pkg::BYTE_REALTIME_MIN) return 1'b0;
      if (in_sysex) begin
         if (b == mrsp_pkg::BYTE_SYSEX_END) begin
            in_sysex = 1'b0;
            return 1'b0;
         end
         if (!b[7]) return 1'b0;
         in_sysex = 1'b0;
      end
      if (b[7]) begin
         if (b == mrsp_pkg::BYTE_SYSEX_START) begin
            in_sysex = 1'b1;
            cur_status = mrsp_pkg::NO_STATUS;
            have_first = 1'b0;
            return 1'b0;
         end
         if (b >= mrsp_pkg::BYTE_COMMON_MIN) begin
            cur_status = mrsp_pkg::NO_STATUS;
            have_first = 1'b0;
            return 1'b0;
         end
         cur_status = b;
         need_two = !(b[7:4] == mrsp_pkg::TYPE_PROGRAM || b[7:4] == mrsp_pkg::TYPE_PRESSURE);
         have_first = 1'b0;
         return 1'b0;
      end
      if (cur_status == mrsp_pkg::NO_STATUS) return 1'b0;
      if (!have_first) begin
         held_data = b[6:0];
         if (!need_two) begin
            m = decode_message(cur_status, b[6:0], 7'd0);
            return 1'b1;
         end
         have_first = 1'b1;
         return 1'b0;
      end
      m = decode_message(cur_status, held_data, b[6:0]);
      have_first = 1'b0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      midi_msg_type got;
      midi_msg_type want;
      midi_msg_type next_msg;
      if (!reset) begin
         // compare first so a message predicted in this cycle is never matched early
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status_byte, rsp_channel, rsp_event_kind, rsp_data_first,
                   rsp_data_second, rsp_bend_value};
            if (expected_msgs.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: unexpected message st=%h ch=%0d kind=%0d d1=%0d d2=%0d bend=%0d",
                           $realtime, got.status_byte, got.channel, got.kind,
                           got.data_first, got.data_second, got.bend);
               mismatch_count++;
            end else begin
               want = expected_msgs.pop_front();
               if (got.status_byte !== want.status_byte || got.channel !== want.channel ||
                   got.kind !== want.kind || got.data_first !== want.data_first ||
                   got.data_second !== want.data_second || got.bend !== want.bend) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: message mismatch", $realtime);
                     $display("   expected st=%h ch=%0d kind=%0d d1=%0d d2=%0d bend=%0d",
                              want.status_byte, want.channel, want.kind,
                              want.data_first, want.data_second, want.bend);
                     $display("   actual   st=%h ch=%0d kind=%0d d1=%0d d2=%0d bend=%0d",
                              got.status_byte, got.channel, got.kind,
                              got.data_first, got.data_second, got.bend);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_midi_byte, next_msg)) expected_msgs.push_back(next_msg);
         end
      end
      pending_count <= expected_msgs.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI running-status parser testbench
// Feeds the parser a directed byte sequence covering every message kind and
// the sysex, realtime and system-common corner cases, then random streams of
// mostly well-formed messages with noise mixed in. Both channels stall at
// random. A separate checker predicts and compares the message transfers.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 1500;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_midi_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_status_byte;
   logic [3:0]         rsp_channel;
   logic [2:0]         rsp_event_kind;
   logic [6:0]         rsp_data_first;
   logic [6:0]         rsp_data_second;
   logic signed [13:0] rsp_bend_value;

   logic steady = 1'b0;
   int   cycle_count = 0;
   int   byte_count = 0;
   int   mismatch_count;
   int   pending_count;

   midi_running_status_parser_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_midi_byte   (req_midi_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status_byte (rsp_status_byte),
      .rsp_channel     (rsp_channel),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_data_first  (rsp_data_first),
      .rsp_data_second (rsp_data_second),
      .rsp_bend_value  (rsp_bend_value)
   );

   midi_message_checker message_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_midi_byte   (req_midi_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status_byte (rsp_status_byte),
      .rsp_channel     (rsp_channel),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_data_first  (rsp_data_first),
      .rsp_data_second (rsp_data_second),
      .rsp_bend_value  (rsp_bend_value),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 11);
   end

   // one byte transfer; starts and ends at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_midi_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (b < mrsp_pkg::BYTE_REALTIME_MIN) byte_count++;
      @(negedge clock);
   endtask

   function automatic logic [6:0] rand_data();
      case ($urandom_range(7))
         0: return 7'd0;
         1: return 7'h7F;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   task automatic maybe_realtime();
      if ($urandom_range(15) == 0)
         send_byte(8'($urandom_range(mrsp_pkg::BYTE_REALTIME_MIN,
                                     {mrsp_pkg::TYPE_SYSTEM, 4'hF})));
   endtask

   initial begin
      logic [7:0] st;
      int         n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // realtime with no status, note on, running status with zero velocity
      send_byte({mrsp_pkg::TYPE_SYSTEM, 4'hF});
      send_byte({mrsp_pkg::TYPE_NOTE_ON, 4'h0}); send_byte(8'd60); send_byte(8'd100);
      send_byte(8'd0); send_byte(8'd0);
      send_byte({mrsp_pkg::TYPE_NOTE_OFF, 4'hF}); send_byte(8'h7F); send_byte(8'h7F);
      // bend extremes, realtime between data bytes
      send_byte({mrsp_pkg::TYPE_BEND, 4'h0}); send_byte(8'd0); send_byte(8'd0);
      send_byte(8'h7F); send_byte(mrsp_pkg::BYTE_REALTIME_MIN); send_byte(8'h7F);
      send_byte({mrsp_pkg::TYPE_PROGRAM, 4'h3}); send_byte(8'h7F);
      send_byte({mrsp_pkg::TYPE_PRESSURE, 4'h0}); send_byte(8'd85);
      // new status drops a held first data byte
      send_byte({mrsp_pkg::TYPE_POLY_PRESSURE, 4'h2}); send_byte(8'd16);
      send_byte({mrsp_pkg::TYPE_CTRL, 4'h0}); send_byte(8'd7); send_byte(8'd64);
      // sysex with realtime inside, aborted by a channel status
      send_byte(mrsp_pkg::BYTE_SYSEX_START); send_byte(8'd18);
      send_byte({mrsp_pkg::TYPE_SYSTEM, 4'hA});
      send_byte({mrsp_pkg::TYPE_NOTE_ON, 4'h3}); send_byte(8'd64); send_byte(8'd32);
      // sysex closed normally, orphan data, system common and abort by system common
      send_byte(mrsp_pkg::BYTE_SYSEX_START); send_byte(8'd51);
      send_byte(mrsp_pkg::BYTE_SYSEX_END);
      send_byte(8'd5);
      send_byte({mrsp_pkg::TYPE_CTRL, 4'h1}); send_byte(mrsp_pkg::BYTE_COMMON_MIN);
      send_byte(8'd9);
      send_byte(mrsp_pkg::BYTE_SYSEX_START); send_byte(mrsp_pkg::BYTE_SYSEX_END - 8'd1);
      send_byte(8'd9);
      send_byte(mrsp_pkg::BYTE_SYSEX_END); send_byte(8'd1);

      byte_count = 0;
      while (byte_count < RANDOM_BYTES) begin
         steady <= (byte_count >= 600 && byte_count < 900);
         case ($urandom_range(9))
            7: begin
               send_byte(mrsp_pkg::BYTE_SYSEX_START);
               repeat ($urandom_range(5)) begin
                  send_byte({1'b0, rand_data()});
                  maybe_realtime();
               end
               if ($urandom_range(2) != 0) send_byte(mrsp_pkg::BYTE_SYSEX_END);
               else send_byte(8'($urandom_range({mrsp_pkg::TYPE_NOTE_OFF, 4'h0},
                                                mrsp_pkg::BYTE_SYSEX_END - 8'd1)));
            end
            8: begin
               send_byte(8'($urandom_range(mrsp_pkg::BYTE_COMMON_MIN,
                                           mrsp_pkg::BYTE_SYSEX_END)));
               send_byte({1'b0, rand_data()});
            end
            9: begin
               repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end
            default: begin
               st = {4'($urandom_range(mrsp_pkg::TYPE_NOTE_OFF, mrsp_pkg::TYPE_BEND)),
                     4'($urandom_range(15))};
               n = (st[7:4] == mrsp_pkg::TYPE_PROGRAM ||
                    st[7:4] == mrsp_pkg::TYPE_PRESSURE) ? 1 : 2;
               send_byte(st);
               repeat ($urandom_range(1, 4)) begin
                  // occasionally cut a message short
                  if ($urandom_range(19) == 0) send_byte({1'b0, rand_data()});
                  else
                     for (int k = 0; k < n; k++) begin
                        maybe_realtime();
                        send_byte({1'b0, rand_data()});
                     end
               end
            end
         endcase
      end

      req_valid <= 1'b0;
      steady <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
